/* design/aqi_pkg.sv */
`timescale 1ns / 1ps
package aqi_pkg;

  localparam int SEGMENTS   = 7;
  localparam int TABLE_ROWS = 7;
  localparam int ROWS       = (SEGMENTS < TABLE_ROWS) ? SEGMENTS : TABLE_ROWS;

  localparam int NSTAGES = 6;

  localparam int CONC_W   = 14;
  localparam int COARSE_W = 11;
  localparam int BP_W     = 13;
  localparam int IDX_W    = 9;
  localparam int RISE_W   = 7;
  localparam int SPAN_W   = 11;
  localparam int RECIP_W  = 14;
  localparam int NUM_W    = 19;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam int DEN_W    = SPAN_W + 1;

  localparam int RECIP_SHIFT = 20;

  localparam int DIV10_SHIFT = 19;
  localparam logic [15:0] DIV10_MUL = 16'd52429;

  typedef struct packed {
    logic [CONC_W-1:0] fine_dust_tenths;
    logic [CONC_W-1:0] coarse_dust_tenths;
  } aqi_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] fine_index;
    logic             fine_valid;
    logic [IDX_W-1:0] coarse_index;
    logic             coarse_valid;
    logic [IDX_W-1:0] overall_index;
    logic             overall_valid;
  } aqi_out_t;

  // recip = floor(2^RECIP_SHIFT / (2 * span))
  typedef struct packed {
    logic [BP_W-1:0]    lo;
    logic [BP_W-1:0]    hi;
    logic [IDX_W-1:0]   ilo;
    logic [RISE_W-1:0]  rise;
    logic [SPAN_W-1:0]  span;
    logic [RECIP_W-1:0] recip;
  } aqi_seg_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } aqi_lane_en_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             valid;
  } aqi_lane_res_t;

  // PM2.5 in 0.1 ug/m3
  localparam aqi_seg_t FINE_TAB [TABLE_ROWS] = '{
    '{13'd0,    13'd120,  9'd0,   7'd50, 11'd120,  14'd4369},
    '{13'd121,  13'd354,  9'd51,  7'd49, 11'd233,  14'd2250},
    '{13'd355,  13'd554,  9'd101, 7'd49, 11'd199,  14'd2634},
    '{13'd555,  13'd1504, 9'd151, 7'd49, 11'd949,  14'd552},
    '{13'd1505, 13'd2504, 9'd201, 7'd99, 11'd999,  14'd524},
    '{13'd2505, 13'd3504, 9'd301, 7'd99, 11'd999,  14'd524},
    '{13'd3505, 13'd5004, 9'd401, 7'd99, 11'd1499, 14'd349}
  };

  // PM10 in whole ug/m3
  localparam aqi_seg_t COARSE_TAB [TABLE_ROWS] = '{
    '{13'd0,   13'd54,  9'd0,   7'd50, 11'd54, 14'd9709},
    '{13'd55,  13'd154, 9'd51,  7'd49, 11'd99, 14'd5295},
    '{13'd155, 13'd254, 9'd101, 7'd49, 11'd99, 14'd5295},
    '{13'd255, 13'd354, 9'd151, 7'd49, 11'd99, 14'd5295},
    '{13'd355, 13'd424, 9'd201, 7'd99, 11'd69, 14'd7598},
    '{13'd425, 13'd504, 9'd301, 7'd99, 11'd79, 14'd6636},
    '{13'd505, 13'd604, 9'd401, 7'd99, 11'd99, 14'd5295}
  };

endpackage

/* design/aqi_prescale.sv */
`timescale 1ns / 1ps
module aqi_prescale (
  input  logic               clk_i,
  input  logic               en_i,
  input  aqi_pkg::aqi_in_t   in_data_i,
  output logic [13:0]        fine_o,
  output logic [10:0]        coarse_o
);
  import aqi_pkg::*;

  logic [CONC_W+15:0]   prod;
  logic [CONC_W-1:0]    fine_q;
  logic [COARSE_W-1:0]  coarse_d, coarse_q;

  // x / 10 by reciprocal, exact over the 14-bit input range
  assign prod     = (CONC_W+16)'(in_data_i.coarse_dust_tenths) * (CONC_W+16)'(DIV10_MUL);
  assign coarse_d = prod[DIV10_SHIFT+COARSE_W-1:DIV10_SHIFT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fine_q   <= in_data_i.fine_dust_tenths;
      coarse_q <= coarse_d;
    end
  end

  assign fine_o   = fine_q;
  assign coarse_o = coarse_q;

endmodule

/* design/aqi_lane.sv */
`timescale 1ns / 1ps
module aqi_lane (
  input  logic                   clk_i,
  input  aqi_pkg::aqi_lane_en_t  en_i,
  input  logic                   tab_sel_i,
  input  logic [13:0]            conc_i,
  output aqi_pkg::aqi_lane_res_t res_o
);
  import aqi_pkg::*;

  // stage 2: segment search
  logic              hit_d, hit2_q;
  aqi_seg_t          seg_d, seg2_q;
  logic [SPAN_W-1:0] off_d, off2_q;

  always_comb begin
    aqi_seg_t row;
    hit_d = 1'b0;
    seg_d = FINE_TAB[0];
    for (int k = ROWS - 1; k >= 0; k--) begin
      row = tab_sel_i ? COARSE_TAB[k] : FINE_TAB[k];
      if (conc_i >= {1'b0, row.lo} && conc_i <= {1'b0, row.hi}) begin
        hit_d = 1'b1;
        seg_d = row;
      end
    end
    off_d = SPAN_W'(conc_i - {1'b0, seg_d.lo});
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      hit2_q <= hit_d;
      seg2_q <= seg_d;
      off2_q <= off_d;
    end
  end

  // stage 3: numerator 2*rise*off + span
  logic [RISE_W+SPAN_W-1:0] ro;
  logic [NUM_W-1:0]         n_d, n3_q;
  logic                     hit3_q;
  aqi_seg_t                 seg3_q;

  assign ro  = (RISE_W+SPAN_W)'(seg2_q.rise) * (RISE_W+SPAN_W)'(off2_q);
  assign n_d = {ro, 1'b0} + NUM_W'(seg2_q.span);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      hit3_q <= hit2_q;
      seg3_q <= seg2_q;
      n3_q   <= n_d;
    end
  end

  // stage 4: multiply by segment reciprocal
  logic [PROD_W-1:0] p_d, p4_q;
  logic [NUM_W-1:0]  n4_q;
  logic              hit4_q;
  aqi_seg_t          seg4_q;

  assign p_d = PROD_W'(n3_q) * PROD_W'(seg3_q.recip);

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      hit4_q <= hit3_q;
      seg4_q <= seg3_q;
      n4_q   <= n3_q;
      p4_q   <= p_d;
    end
  end

  // stage 5: estimate is exact or one low; one correction step
  logic [RISE_W-1:0] q0, q_d, q5_q;
  logic [DEN_W-1:0]  den;
  logic [NUM_W-1:0]  qden, rem;
  logic              hit5_q;
  logic [IDX_W-1:0]  ilo5_q;

  assign q0   = p4_q[RECIP_SHIFT+RISE_W-1:RECIP_SHIFT];
  assign den  = {seg4_q.span, 1'b0};
  assign qden = NUM_W'(q0) * NUM_W'(den);
  assign rem  = n4_q - qden;
  assign q_d  = q0 + RISE_W'(rem >= NUM_W'(den));

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      hit5_q <= hit4_q;
      ilo5_q <= seg4_q.ilo;
      q5_q   <= q_d;
    end
  end

  assign res_o.valid = hit5_q;
  assign res_o.index = hit5_q ? (ilo5_q + IDX_W'(q5_q)) : '0;

endmodule

/* design/particulate_air_quality_index.sv */
// Flow: an accepted input word passes through every registered stage to its output word.
// Throughput: one word per cycle while out_stall_i is low; every stage holds one word in flight.
// Depth is set by the div-by-10, segment search, numerator multiply,
// reciprocal multiply and correction stages plus the output register.
// Reset: async active low, clears all stage valid bits; pipeline is empty.
`timescale 1ns / 1ps
module particulate_air_quality_index (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  aqi_pkg::aqi_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output aqi_pkg::aqi_out_t out_data_o
);
  import aqi_pkg::*;

  logic [NSTAGES-1:0] v_d, v_q, adv;

  always_comb begin
    adv[NSTAGES-1] = !v_q[NSTAGES-1] || !out_stall_i;
    for (int k = NSTAGES - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    for (int k = 0; k < NSTAGES; k++) begin
      if (adv[k]) begin
        v_d[k] = (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o = !adv[0];

  logic [CONC_W-1:0]   fine_c;
  logic [COARSE_W-1:0] coarse_c;

  aqi_prescale u_prescale (
    .clk_i     (clk_i),
    .en_i      (adv[0]),
    .in_data_i (in_data_i),
    .fine_o    (fine_c),
    .coarse_o  (coarse_c)
  );

  aqi_lane_en_t  lane_en;
  aqi_lane_res_t fine_res, coarse_res;

  assign lane_en.s2 = adv[1];
  assign lane_en.s3 = adv[2];
  assign lane_en.s4 = adv[3];
  assign lane_en.s5 = adv[4];

  aqi_lane u_fine (
    .clk_i     (clk_i),
    .en_i      (lane_en),
    .tab_sel_i (1'b0),
    .conc_i    (fine_c),
    .res_o     (fine_res)
  );

  aqi_lane u_coarse (
    .clk_i     (clk_i),
    .en_i      (lane_en),
    .tab_sel_i (1'b1),
    .conc_i    (CONC_W'(coarse_c)),
    .res_o     (coarse_res)
  );

  aqi_out_t out_d, out_q;

  always_comb begin
    out_d.fine_index    = fine_res.index;
    out_d.fine_valid    = fine_res.valid;
    out_d.coarse_index  = coarse_res.index;
    out_d.coarse_valid  = coarse_res.valid;
    out_d.overall_index = (coarse_res.index > fine_res.index) ? coarse_res.index
                                                              : fine_res.index;
    out_d.overall_valid = fine_res.valid || coarse_res.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv[NSTAGES-1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NSTAGES-1];
  assign out_data_o  = out_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_overall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overall_valid ==
                     (out_data_o.fine_valid || out_data_o.coarse_valid)))
    else $error("overall valid does not match lane valids");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.fine_valid || out_data_o.fine_index == '0) &&
                     (out_data_o.coarse_valid || out_data_o.coarse_index == '0)))
    else $error("index nonzero without valid");

  a_overall_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.overall_index >= out_data_o.fine_index &&
                     out_data_o.overall_index >= out_data_o.coarse_index))
    else $error("overall index below a lane index");

endmodule

/* tb/sv/aqi_checker.sv */
`timescale 1ns / 1ps
module aqi_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  aqi_pkg::aqi_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  aqi_pkg::aqi_out_t out_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  import aqi_pkg::*;

  localparam int BP_ROWS = 7;
  localparam int C_LO = 0;
  localparam int C_HI = 1;
  localparam int I_LO = 2;
  localparam int I_HI = 3;

  // PM2.5 breakpoints in 0.1 ug/m3
  localparam int unsigned FINE_BP [BP_ROWS][4] = '{
    '{0, 120, 0, 50},
    '{121, 354, 51, 100},
    '{355, 554, 101, 150},
    '{555, 1504, 151, 200},
    '{1505, 2504, 201, 300},
    '{2505, 3504, 301, 400},
    '{3505, 5004, 401, 500}
  };

  // PM10 breakpoints in whole ug/m3
  localparam int unsigned COARSE_BP [BP_ROWS][4] = '{
    '{0, 54, 0, 50},
    '{55, 154, 51, 100},
    '{155, 254, 101, 150},
    '{255, 354, 151, 200},
    '{355, 424, 201, 300},
    '{425, 504, 301, 400},
    '{505, 604, 401, 500}
  };

  aqi_out_t expected_aqi_q[$];
  int       fail_count = 0;
  int       checked = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_aqi_q.size();
  assign checked_o    = checked;

  function automatic aqi_lane_res_t segment_aqi(input bit coarse, input int unsigned conc);
    aqi_lane_res_t res;
    int unsigned   row [4];
    int unsigned   span;
    int unsigned   rise;
    int            rows;
    res  = '0;
    rows = (SEGMENTS < BP_ROWS) ? SEGMENTS : BP_ROWS;
    for (int i = 0; i < rows; i++) begin
      if (coarse) begin
        row = COARSE_BP[i];
      end else begin
        row = FINE_BP[i];
      end
      if (!res.valid && conc >= row[C_LO] && conc <= row[C_HI]) begin
        span = row[C_HI] - row[C_LO];
        rise = row[I_HI] - row[I_LO];
        res.valid = 1'b1;
        if (span == 0) begin
          res.index = IDX_W'(row[I_LO]);
        end else begin
          res.index = IDX_W'((2 * rise * (conc - row[C_LO]) + span) / (2 * span)
                             + row[I_LO]);
        end
      end
    end
    return res;
  endfunction

  function automatic aqi_out_t predict_aqi(input aqi_in_t w);
    aqi_out_t      r;
    aqi_lane_res_t f;
    aqi_lane_res_t c;
    f = segment_aqi(1'b0, 32'(w.fine_dust_tenths));
    c = segment_aqi(1'b1, 32'(w.coarse_dust_tenths) / 10);
    r.fine_index    = f.index;
    r.fine_valid    = f.valid;
    r.coarse_index  = c.index;
    r.coarse_valid  = c.valid;
    r.overall_index = f.valid ? f.index : '0;
    if (c.valid && c.index > r.overall_index) begin
      r.overall_index = c.index;
    end
    r.overall_valid = f.valid | c.valid;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    aqi_out_t exp_w;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_aqi_q.size() == 0) begin
          $error("unexpected result word: %h", out_data_i);
          fail_count++;
        end else begin
          exp_w = expected_aqi_q.pop_front();
          check_field("fine_index", int'(exp_w.fine_index), int'(out_data_i.fine_index));
          check_field("fine_valid", int'(exp_w.fine_valid), int'(out_data_i.fine_valid));
          check_field("coarse_index", int'(exp_w.coarse_index),
                      int'(out_data_i.coarse_index));
          check_field("coarse_valid", int'(exp_w.coarse_valid),
                      int'(out_data_i.coarse_valid));
          check_field("overall_index", int'(exp_w.overall_index),
                      int'(out_data_i.overall_index));
          check_field("overall_valid", int'(exp_w.overall_valid),
                      int'(out_data_i.overall_valid));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_aqi_q.push_back(predict_aqi(in_data_i));
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import aqi_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_e;

  localparam int N_DIRECTED = 20;
  localparam int N_RANDOM   = 1250;
  localparam int TAIL_CYCLES = 16;

  localparam logic [CONC_W-1:0] FINE_DIR [N_DIRECTED] = '{
    0, 6, 120, 121, 354, 355, 554, 555, 1504, 1505,
    2504, 2505, 3504, 3505, 5004, 5005, 16383, 8191, 0, 2000
  };
  localparam logic [CONC_W-1:0] COARSE_DIR [N_DIRECTED] = '{
    0, 549, 550, 1549, 1550, 2549, 2550, 3549, 3550, 4249,
    4250, 5049, 5050, 6049, 6050, 16383, 0, 8192, 6050, 100
  };

  // segment tops: fine in 0.1 ug/m3, coarse in whole ug/m3
  localparam int unsigned FINE_TOPS [7]   = '{120, 354, 554, 1504, 2504, 3504, 5004};
  localparam int unsigned COARSE_TOPS [7] = '{54, 154, 254, 354, 424, 504, 604};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  aqi_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  aqi_out_t out_data_o;

  int fail_count;
  int pending_words;
  int checked_words;
  int sent_words = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;

  particulate_air_quality_index dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  aqi_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_words),
    .checked_o   (checked_words)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver backpressure: random stretches of free flow, light, heavy and solid stall
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= 1'b1;
    endcase
  end

  initial begin
    #1000000;
    $display("particulate_air_quality_index test failed");
    $finish;
  end

  function automatic logic [CONC_W-1:0] pick_conc(input bit coarse);
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, 6);
    if (sel < 10) begin
      return CONC_W'($urandom_range(0, 16383));
    end else if (sel < 35) begin
      if (coarse) begin
        return CONC_W'((COARSE_TOPS[k] + $urandom_range(0, 2) - 1) * 10
                       + $urandom_range(0, 9));
      end
      return CONC_W'(FINE_TOPS[k] + $urandom_range(0, 2) - 1);
    end
    return coarse ? CONC_W'($urandom_range(0, 6049)) : CONC_W'($urandom_range(0, 5004));
  endfunction

  int burst_left = 0;

  task automatic push_word(input aqi_in_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sent_words++;
  endtask

  initial begin
    aqi_in_t w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      w.fine_dust_tenths   = FINE_DIR[i];
      w.coarse_dust_tenths = COARSE_DIR[i];
      push_word(w);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      w.fine_dust_tenths   = pick_conc(1'b0);
      w.coarse_dust_tenths = pick_conc(1'b1);
      push_word(w);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d sample words (breakpoint edges, out-of-table values, random mix).",
             sent_words);
    $display("Checked %0d index words under random sender gaps and receiver stalls.",
             checked_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("particulate_air_quality_index test passed");
    end else begin
      $display("particulate_air_quality_index test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/aqi_pkg.sv
design/aqi_prescale.sv
design/aqi_lane.sv
design/particulate_air_quality_index.sv
tb/sv/aqi_checker.sv
tb/sv/tb_top.sv
